>>> hw/rtl/smbd_pkg.sv
// shared constants for the sparse mask block decoder
package smbd_pkg;

	localparam int TOKEN_BITS     = 24;
	localparam int BLOCK_LEN_DEF  = 16;
	localparam int VALUE_BITS_DEF = 24;

	typedef logic signed [TOKEN_BITS-1:0] token_t;

endpackage

>>> hw/rtl/smbd_sat_add.sv
// saturating adder shared by every decoded position
module smbd_sat_add #(
	parameter int VALUE_BITS = smbd_pkg::VALUE_BITS_DEF
) (
	input  smbd_pkg::token_t a,
	input  smbd_pkg::token_t b,
	output smbd_pkg::token_t y
);
	import smbd_pkg::*;

	localparam int EXT_BITS = 33;
	localparam logic signed [EXT_BITS-1:0] SAT_HI =
		(EXT_BITS'(1) <<< (VALUE_BITS - 1)) - EXT_BITS'(1);
	localparam logic signed [EXT_BITS-1:0] SAT_LO = -SAT_HI - EXT_BITS'(1);

	logic signed [TOKEN_BITS:0]   sum;
	logic signed [EXT_BITS-1:0]   sum_ext;
	logic signed [EXT_BITS-1:0]   clamped;

	assign sum     = (TOKEN_BITS+1)'(a) + (TOKEN_BITS+1)'(b);
	assign sum_ext = EXT_BITS'(sum);

	always_comb begin
		if (sum_ext > SAT_HI) begin
			clamped = SAT_HI;
		end else if (sum_ext < SAT_LO) begin
			clamped = SAT_LO;
		end else begin
			clamped = sum_ext;
		end
	end

	assign y = clamped[TOKEN_BITS-1:0];

endmodule

>>> hw/rtl/sparse_mask_block_decoder.sv
// top level of the sparse mask block decoder
// m_tvalid rises in the cycle after the token or step that makes the result
// base and mask tokens are taken whenever valid; then one result per cycle while the output
// slot is free and every set bit has its delta, from the single shared saturating adder
// a delta token is taken only in the cycle its position is emitted
// reset: asynchronous, active low; sequencer waits for a base, output empty
module sparse_mask_block_decoder #(
	parameter int BLOCK_LEN  = smbd_pkg::BLOCK_LEN_DEF,
	parameter int VALUE_BITS = smbd_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  smbd_pkg::token_t s_tdata,  // [23:0] token
	output logic             m_tvalid,
	input  logic             m_tready,
	output smbd_pkg::token_t m_tdata,  // [23:0] value
	output logic             m_tlast   // block_end
);
	import smbd_pkg::*;

	localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

	// one-hot sequencer: base token, mask token, then one step per position
	typedef enum logic [2:0] {
		ST_BASE = 3'b001,
		ST_MASK = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	state_t               state_q;
	token_t               base_q;
	logic [BLOCK_LEN-1:0] mask_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     bit_idx;

	logic                 m_tvalid_q;
	token_t               m_tdata_q;
	logic                 m_tlast_q;

	logic                 slot_free;   // output register can take a result
	logic                 bit_now;     // presence bit of the current position
	logic                 pos_last;
	logic                 emit;
	token_t               add_b;
	token_t               sum;

	// position 0 reads the most significant mask bit
	assign bit_idx   = POS_W'(BLOCK_LEN - 1) - pos_q;
	assign bit_now   = mask_q[bit_idx];
	assign pos_last  = (pos_q == POS_W'(BLOCK_LEN - 1));
	assign slot_free = !m_tvalid_q || m_tready;

	// clear bits add nothing, so the adder still clamps the bare base
	assign add_b = bit_now ? s_tdata : '0;

	smbd_sat_add #(
		.VALUE_BITS(VALUE_BITS)
	) u_sat_add (
		.a(base_q),
		.b(add_b),
		.y(sum)
	);

	always_comb begin
		s_tready = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_BASE, ST_MASK: begin
				s_tready = 1'b1;
			end
			ST_RUN: begin
				// a set bit waits for its delta transaction, a clear bit goes at once
				s_tready = bit_now && slot_free;
				emit     = slot_free && (!bit_now || s_tvalid);
			end
			default: begin
				s_tready = 1'b0;
				emit     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BASE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_BASE: begin
					if (s_tvalid) begin
						state_q <= ST_MASK;
					end
				end
				ST_MASK: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
						pos_q   <= '0;
					end
				end
				ST_RUN: begin
					if (emit) begin
						if (pos_last) begin
							state_q <= ST_BASE;
							pos_q   <= '0;
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_BASE;
					pos_q   <= '0;
				end
			endcase
		end
	end

	// block payload, loaded by the base and mask transactions
	always_ff @(posedge clk) begin
		if (state_q == ST_BASE && s_tvalid) begin
			base_q <= s_tdata;
		end
		if (state_q == ST_MASK && s_tvalid) begin
			// only the low BLOCK_LEN bits of the mask token count
			mask_q <= BLOCK_LEN'($unsigned(s_tdata));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= sum;
			m_tlast_q <= pos_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> test/sparse_mask_block_decoder_tb.sv
// self-checking testbench for the sparse mask block decoder
module sparse_mask_block_decoder_tb;
	import smbd_pkg::*;

	localparam int BLK           = BLOCK_LEN_DEF;
	localparam int VBITS         = VALUE_BITS_DEF;
	localparam int RANDOM_TOKENS = 460;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 120;
	localparam int CALM_FROM     = 300;
	localparam int CALM_TO       = 360;

	typedef enum logic [1:0] {WANT_BASE, WANT_MASK, WANT_DELTA} stage_t;

	typedef struct packed {
		token_t value;
		logic   last;
	} sample_t;

	// tracks the token phase and queues the decoded samples each token releases
	class decode_tracker;
		stage_t         stage;
		token_t         base;
		logic [BLK-1:0] mask;
		int             pos;
		sample_t        pending_samples[$];
		int             errors;

		function new();
			stage  = WANT_BASE;
			base   = '0;
			mask   = '0;
			pos    = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function token_t clamp(longint v);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (VBITS - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) v = hi;
			if (v < lo) v = lo;
			return token_t'(v[TOKEN_BITS-1:0]);
		endfunction

		function void emit_sample(longint v);
			sample_t s;
			s.value = clamp(v);
			s.last  = (pos == BLK - 1);
			pending_samples.push_back(s);
			pos++;
			if (pos >= BLK) begin
				pos   = 0;
				stage = WANT_BASE;
			end
		endfunction

		// base-only positions up to the next set bit or the block end
		function void emit_base_run();
			while (stage == WANT_DELTA && !mask[BLK-1-pos])
				emit_sample(longint'(base));
		endfunction

		function void take_token(token_t t);
			case (stage)
				WANT_MASK: begin
					mask  = t[BLK-1:0];
					pos   = 0;
					stage = WANT_DELTA;
					emit_base_run();
				end
				WANT_DELTA: begin
					emit_sample(longint'(base) + longint'(t));
					emit_base_run();
				end
				default: begin
					base  = t;
					stage = WANT_MASK;
				end
			endcase
		endfunction

		task match_sample(token_t v, logic l);
			sample_t s;
			if (pending_samples.size() == 0) begin
				report($sformatf("unexpected value %0d last %0b", v, l));
				return;
			end
			s = pending_samples.pop_front();
			if (v !== s.value)
				report($sformatf("value %0d, wanted %0d", v, s.value));
			if (l !== s.last)
				report($sformatf("last %0b, wanted %0b (value %0d)", l, s.last, s.value));
		endtask
	endclass

	logic   clk;
	logic   arst_n;
	logic   s_tvalid;
	logic   s_tready;
	token_t s_tdata;
	logic   m_tvalid;
	logic   m_tready;
	token_t m_tdata;
	logic   m_tlast;

	decode_tracker tracker = new();
	int            tokens_sent = 0;
	logic          calm;

	// window with no idling on either side
	assign calm = (tokens_sent >= CALM_FROM) && (tokens_sent < CALM_TO);

	sparse_mask_block_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic token_t pick_value();
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return '0;
			3, 4, 5: return token_t'($urandom_range(0, 20000)) - token_t'(10000);
			default: return token_t'($urandom);
		endcase
	endfunction

	function automatic token_t pick_mask();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 24'sh00FFFF;
			2: return token_t'(1 << $urandom_range(0, BLK - 1));
			3: return token_t'($urandom);
			default: return token_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic send_token(input token_t t);
		int gap;
		gap = calm ? 0 : random_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
		tracker.take_token(t);
		tokens_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_sample(m_tdata, m_tlast);
	end

	// receiver side, including one long hold-off so the input backs up
	initial begin
		int  stall;
		int  run;
		bit  held;
		held = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && tokens_sent >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = random_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				run = $urandom_range(1, 12);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		token_t b;
		token_t m;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top saturation, first and last positions set
		send_token(24'sh7FFFFF);
		send_token(24'sh008001);
		send_token(24'sh7FFFFF);
		send_token(24'sh000001);
		// bottom saturation, mask with junk above the block bits
		send_token(24'sh800000);
		send_token(24'shFF0001);
		send_token(24'sh800000);
		// empty mask releases the whole block at once
		send_token(24'sh000123);
		send_token(24'sh000000);
		// clear positions on both sides of a single delta
		send_token(-token_t'(250));
		send_token(24'sh004000);
		send_token(24'sh000064);
		// only out-of-range mask bits set
		send_token(24'shAAAAAA);
		send_token(24'shF00000);

		while (tokens_sent < 14 + RANDOM_TOKENS) begin
			b = pick_value();
			m = pick_mask();
			send_token(b);
			send_token(m);
			for (int i = 0; i < BLK; i++)
				if (m[i]) send_token(pick_value());
		end
		s_tvalid <= 1'b0;

		while (tracker.pending_samples.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
